>>> src/dfwg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfwg_pkg
// Shared types and constants for the DShot frame waveform generator.
// ----------------------------------------------------------------------------
package dfwg_pkg;

    // Field widths
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned THR_W      = 11;
    localparam int unsigned FRAME_W    = 16;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned PERIOD_W   = 12;
    localparam int unsigned GAP_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_DATA_W   = 16;
    localparam int unsigned M_DATA_W   = 8;

    // Command codes carried in tuser
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP        = 2'd3;

    // Configuration reset values
    localparam logic [PERIOD_W-1:0] RST_BIT_PERIOD = 12'd66;
    localparam logic [PERIOD_W-1:0] RST_ONE_HIGH   = 12'd49;
    localparam logic [PERIOD_W-1:0] RST_ZERO_HIGH  = 12'd24;
    localparam logic [GAP_W-1:0]    RST_GAP        = 16'd2000;

    // Bit position that marks the inter-frame gap
    localparam logic [POS_W-1:0] GAP_POS = 5'd16;

    typedef struct packed {
        logic [PERIOD_W-1:0] bit_period;
        logic [PERIOD_W-1:0] one_high;
        logic [PERIOD_W-1:0] zero_high;
        logic [GAP_W-1:0]    gap;
    } dfwg_cfg_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_word;
        logic [POS_W-1:0]   bit_pos;
        logic [TICK_W-1:0]  tick;
        logic               active;
    } dfwg_state_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [THR_W-1:0] throttle;
        logic             telemetry_request;
    } dfwg_item_t;

    typedef struct packed {
        logic running;
        logic in_gap;
        logic frame_start;
        logic pin_level;
    } dfwg_result_t;

endpackage

>>> src/dshot_frame_waveform_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshot_frame_waveform_generator_unit
// DShot frame encoder driven by one timing tick per input request.
// ----------------------------------------------------------------------------
// Each input request is one tick of the timing base and yields exactly one
// output request carrying the line level and frame flags for that tick. The
// unit takes one request per clock cycle while m_tready allows it; an accepted
// request passes the input register, then the result register. The rate
// is set by the sequencer state (frame word, bit position, tick counter),
// which is read and rewritten in the same cycle for each tick. Timing
// registers are written through the cfg channel, which is always ready.
module dshot_frame_waveform_generator_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Tick requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dfwg_pkg::S_DATA_W-1:0]   s_tdata,  // [10:0] throttle, [11] telemetry_request
    input  logic [dfwg_pkg::CMD_W-1:0]      s_tuser,  // [1:0] cmd
    // Tick results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dfwg_pkg::M_DATA_W-1:0]   m_tdata,  // [0] pin_level, [1] frame_start,
                                                      // [2] in_gap, [3] running
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dfwg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfwg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dfwg_pkg::*;

    dfwg_cfg_t    cfg;
    logic         in_valid_reg;
    dfwg_item_t   in_item_reg;
    dfwg_state_t  state_reg;
    dfwg_state_t  state_next;
    dfwg_result_t step_result;
    logic         out_valid_reg;
    dfwg_result_t out_result_reg;
    logic         advance;
    logic         s_accept;

    assign cfg_ready = 1'b1;

    dfwg_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    dfwg_step u_step
    (
        .cfg       (cfg),
        .state_cur (state_reg),
        .item      (in_item_reg),
        .state_new (state_next),
        .result    (step_result)
    );

    // Handshake: move a request forward when the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.cmd               <= s_tuser;
            in_item_reg.throttle          <= s_tdata[THR_W-1:0];
            in_item_reg.telemetry_request <= s_tdata[THR_W];
        end
    end

    // Sequencer state, updated once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_result_reg};

endmodule

>>> src/dfwg_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfwg_cfg_regs
// Timing register file: bit period, one/zero high times and gap length.
// ----------------------------------------------------------------------------
module dfwg_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [dfwg_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [dfwg_pkg::CFG_DATA_W-1:0] wr_data,
    output dfwg_pkg::dfwg_cfg_t            cfg
);
    import dfwg_pkg::*;

    dfwg_cfg_t cfg_reg;
    dfwg_cfg_t cfg_next;

    // Decode the write request
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_BIT_PERIOD: cfg_next.bit_period = wr_data[PERIOD_W-1:0];
                REG_ONE_HIGH:   cfg_next.one_high   = wr_data[PERIOD_W-1:0];
                REG_ZERO_HIGH:  cfg_next.zero_high  = wr_data[PERIOD_W-1:0];
                REG_GAP:        cfg_next.gap        = wr_data[GAP_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period <= RST_BIT_PERIOD;
            cfg_reg.one_high   <= RST_ONE_HIGH;
            cfg_reg.zero_high  <= RST_ZERO_HIGH;
            cfg_reg.gap        <= RST_GAP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/dfwg_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfwg_step
// One tick of the frame sequencer: applies the command, forms the line
// level and flags, and advances the bit cell / gap counters.
// ----------------------------------------------------------------------------
module dfwg_step
(
    input  dfwg_pkg::dfwg_cfg_t    cfg,
    input  dfwg_pkg::dfwg_state_t  state_cur,
    input  dfwg_pkg::dfwg_item_t   item,
    output dfwg_pkg::dfwg_state_t  state_new,
    output dfwg_pkg::dfwg_result_t result
);
    import dfwg_pkg::*;

    dfwg_state_t         st;
    logic [11:0]         v12;
    logic [3:0]          crc;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] high_raw;
    logic [PERIOD_W-1:0] high;
    logic                bit_val;
    logic [TICK_W:0]     tick_inc;

    // Frame built from the request fields: throttle, telemetry, nibble XOR
    assign v12 = {item.throttle, item.telemetry_request};
    assign crc = v12[3:0] ^ v12[7:4] ^ v12[11:8];

    // Apply the command before the tick
    always_comb
    begin
        st = state_cur;
        unique case (item.cmd)
            CMD_STOP:
            begin
                st.active  = 1'b0;
                st.bit_pos = '0;
                st.tick    = '0;
            end
            CMD_LOAD:
            begin
                st.frame_word = {v12, crc};
                st.bit_pos    = '0;
                st.tick       = '0;
                st.active     = 1'b1;
            end
            default: st = state_cur;
        endcase
    end

    // Cell timing: zero period counts as one tick, high time saturates
    assign period   = (cfg.bit_period == '0) ? PERIOD_W'(1) : cfg.bit_period;
    assign bit_val  = st.frame_word[4'd15 - st.bit_pos[3:0]];
    assign high_raw = bit_val ? cfg.one_high : cfg.zero_high;
    assign high     = (high_raw > period) ? period : high_raw;
    assign tick_inc = {1'b0, st.tick} + (TICK_W+1)'(1);

    // Advance the cell or gap
    always_comb
    begin
        state_new = st;
        result    = '0;
        if (st.active)
        begin
            result.running = 1'b1;
            if (st.bit_pos < GAP_POS)
            begin
                result.pin_level   = (st.tick < TICK_W'(high));
                result.frame_start = (st.bit_pos == '0) && (st.tick == '0);
                state_new.tick     = tick_inc[TICK_W-1:0];
                if (tick_inc >= (TICK_W+1)'(period))
                begin
                    state_new.tick = '0;
                    if ((st.bit_pos == GAP_POS - POS_W'(1)) && (cfg.gap == '0))
                        state_new.bit_pos = '0;
                    else
                        state_new.bit_pos = st.bit_pos + POS_W'(1);
                end
            end
            else
            begin
                result.in_gap  = 1'b1;
                state_new.tick = tick_inc[TICK_W-1:0];
                if (tick_inc >= (TICK_W+1)'(cfg.gap))
                begin
                    state_new.tick    = '0;
                    state_new.bit_pos = '0;
                end
            end
        end
    end

endmodule

>>> src/dfwg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfwg_checker
// Port-level checks for the DShot frame waveform generator, bound to the top.
// ----------------------------------------------------------------------------
module dfwg_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dfwg_pkg::M_DATA_W-1:0]   m_tdata
);
    import dfwg_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Frame start only while running and outside the gap
    a_start_running: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[3] && !m_tdata[2])
        else $error("frame start outside a running frame");

    // Gap keeps the line low
    a_gap_low: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> !m_tdata[0] && m_tdata[3])
        else $error("line high during gap");

    // Idle output is all zero
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[2:0] == 3'b000)
        else $error("activity while not running");

endmodule

bind dshot_frame_waveform_generator_unit dfwg_checker u_dfwg_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DShot frame waveform generator unit.
// ----------------------------------------------------------------------------
// Drives tick requests (tick, load, stop and the spare code) through the
// slave stream and checks every result request against a cycle-free line
// model of the encoder. A short scripted part covers the idle line, the
// spare command, stop, throttle extremes, zero period, saturated high time
// and zero gap. Randomized phases follow, each with its own timing set.
// Timing registers are rewritten only once every pending result has drained.
// Both stream sides stall at random, except during one long steady stretch.
// ----------------------------------------------------------------------------
module tb;

    import dfwg_pkg::*;

    // Spare command code, behaves as a plain tick
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // Known results, bits from the top: running, in_gap, frame_start, pin_level
    localparam dfwg_result_t LINE_IDLE  = 4'b0000;
    localparam dfwg_result_t START_HIGH = 4'b1011;
    localparam dfwg_result_t START_LOW  = 4'b1010;

    localparam int unsigned PHASES      = 12;
    localparam int unsigned PHASE_TICKS = 150;
    localparam int unsigned DRAIN_WAIT  = 4;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned PRINT_LIMIT = 200;

    typedef struct packed {
        logic         reconf;
        dfwg_cfg_t    timing;
        dfwg_item_t   item;
        logic         fixed;
        dfwg_result_t want;
    } script_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [CMD_W-1:0]      s_tuser   = CMD_TICK;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_BIT_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Line model state and its copy of the timing registers
    dfwg_cfg_t         timing = {RST_BIT_PERIOD, RST_ONE_HIGH, RST_ZERO_HIGH, RST_GAP};
    logic [FRAME_W-1:0] frame_bits = '0;
    int unsigned       cell_idx   = 0;
    int unsigned       cell_ticks = 0;
    bit                line_on    = 1'b0;

    dfwg_result_t line_expect[$];
    script_row_t  script[$];
    dfwg_result_t line_want;
    dfwg_result_t line_got;
    int unsigned  mismatches = 0;
    int unsigned  stall_run  = 0;
    bit           steady     = 1'b0;

    dshot_frame_waveform_generator_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advance the line model by one tick and return the line for that tick
    function automatic dfwg_result_t step_waveform(input dfwg_item_t it);
        dfwg_result_t     r;
        logic [11:0]      word12;
        int unsigned      cell_len;
        int unsigned      high;
        r = LINE_IDLE;
        if (it.cmd == CMD_STOP)
        begin
            line_on    = 1'b0;
            cell_idx   = 0;
            cell_ticks = 0;
        end
        else if (it.cmd == CMD_LOAD)
        begin
            word12     = {it.throttle, it.telemetry_request};
            frame_bits = {word12, word12[3:0] ^ word12[7:4] ^ word12[11:8]};
            cell_idx   = 0;
            cell_ticks = 0;
            line_on    = 1'b1;
        end
        if (line_on)
        begin
            cell_len  = (timing.bit_period == '0) ? 1 : 32'(timing.bit_period);
            r.running = 1'b1;
            if (cell_idx < 32'(GAP_POS))
            begin
                high = frame_bits[15 - cell_idx] ? 32'(timing.one_high)
                                                 : 32'(timing.zero_high);
                // Saturate the high time to the cell length
                if (high > cell_len)
                    high = cell_len;
                r.pin_level   = (cell_ticks < high);
                r.frame_start = (cell_idx == 0 && cell_ticks == 0);
                cell_ticks++;
                if (cell_ticks >= cell_len)
                begin
                    cell_ticks = 0;
                    cell_idx++;
                    if (cell_idx == 32'(GAP_POS) && timing.gap == '0)
                        cell_idx = 0;
                end
            end
            else
            begin
                r.in_gap = 1'b1;
                cell_ticks++;
                if (cell_ticks >= 32'(timing.gap))
                begin
                    cell_ticks = 0;
                    cell_idx   = 0;
                end
            end
            cell_ticks = cell_ticks & 32'hFFFF;
        end
        return r;
    endfunction

    function automatic dfwg_item_t random_item();
        dfwg_item_t  it;
        int unsigned roll;
        roll                 = $urandom_range(0, 999);
        it.throttle          = THR_W'($urandom_range(0, 2047));
        it.telemetry_request = 1'($urandom_range(0, 1));
        if (roll < 10)
            it.cmd = CMD_LOAD;
        else if (roll < 15)
            it.cmd = CMD_STOP;
        else if (roll < 25)
            it.cmd = CMD_SPARE;
        else
            it.cmd = CMD_TICK;
        return it;
    endfunction

    // Script builders
    task automatic add_tick(input logic [CMD_W-1:0] cmd, input int unsigned thr,
                            input logic tel);
        script_row_t row;
        row        = '0;
        row.item   = {cmd, thr[THR_W-1:0], tel};
        script.push_back(row);
    endtask

    task automatic add_fixed(input logic [CMD_W-1:0] cmd, input int unsigned thr,
                             input logic tel, input dfwg_result_t want);
        script_row_t row;
        row        = '0;
        row.item   = {cmd, thr[THR_W-1:0], tel};
        row.fixed  = 1'b1;
        row.want   = want;
        script.push_back(row);
    endtask

    task automatic add_timing(input int unsigned period, input int unsigned one,
                              input int unsigned zero, input int unsigned gap);
        script_row_t row;
        row        = '0;
        row.reconf = 1'b1;
        row.timing = {period[PERIOD_W-1:0], one[PERIOD_W-1:0], zero[PERIOD_W-1:0],
                      gap[GAP_W-1:0]};
        script.push_back(row);
    endtask

    // Present one tick request, wait for acceptance, queue its expected line
    task automatic send_tick(input dfwg_item_t it, input logic fixed,
                             input dfwg_result_t want);
        dfwg_result_t got;
        while (!steady && $urandom_range(0, 99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - THR_W - 1){1'b0}}, it.telemetry_request, it.throttle};
        s_tuser  <= it.cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        got = step_waveform(it);
        line_expect.push_back(fixed ? want : got);
    endtask

    // Hold the sender until every pending result has come out
    task automatic drain_line();
        s_tvalid <= 1'b0;
        while (line_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Write all four timing registers; junk above bit 11 of the 12-bit ones must be dropped
    task automatic load_timing(input dfwg_cfg_t t);
        logic [CFG_DATA_W-1:0] word;
        logic [CFG_IDX_W-1:0]  idx;
        for (int k = 0; k < 4; k++)
        begin
            idx  = k[CFG_IDX_W-1:0];
            word = CFG_DATA_W'($urandom);
            case (idx)
                REG_BIT_PERIOD: word[PERIOD_W-1:0] = t.bit_period;
                REG_ONE_HIGH:   word[PERIOD_W-1:0] = t.one_high;
                REG_ZERO_HIGH:  word[PERIOD_W-1:0] = t.zero_high;
                default:        word = t.gap;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= word;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx)
                REG_BIT_PERIOD: timing.bit_period = word[PERIOD_W-1:0];
                REG_ONE_HIGH:   timing.one_high   = word[PERIOD_W-1:0];
                REG_ZERO_HIGH:  timing.zero_high  = word[PERIOD_W-1:0];
                default:        timing.gap        = word;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure and in-order compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                line_got = m_tdata[3:0];
                if (line_expect.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT)
                        $display("%0t: unexpected result %b", $time, line_got);
                end
                else
                begin
                    line_want = line_expect.pop_front();
                    if (line_got.pin_level   !== line_want.pin_level   ||
                        line_got.frame_start !== line_want.frame_start ||
                        line_got.in_gap      !== line_want.in_gap      ||
                        line_got.running     !== line_want.running)
                    begin
                        mismatches++;
                        if (mismatches <= PRINT_LIMIT)
                            $display("%0t: pin/start/gap/run expected %b %b %b %b got %b %b %b %b",
                                     $time, line_want.pin_level, line_want.frame_start,
                                     line_want.in_gap, line_want.running,
                                     line_got.pin_level, line_got.frame_start,
                                     line_got.in_gap, line_got.running);
                    end
                end
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 34);
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_run <= 0;
            else
                stall_run <= stall_run + 1;
            if (stall_run >= STALL_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        dfwg_cfg_t t;

        // Idle line, spare code, stop and a load at reset timing
        add_fixed(CMD_TICK,  0,    1'b0, LINE_IDLE);
        add_fixed(CMD_SPARE, 2047, 1'b1, LINE_IDLE);
        add_fixed(CMD_STOP,  2047, 1'b1, LINE_IDLE);
        add_fixed(CMD_LOAD,  2047, 1'b1, START_HIGH);
        add_tick(CMD_TICK,  0, 1'b0);
        add_tick(CMD_SPARE, 0, 1'b0);
        add_fixed(CMD_STOP, 0, 1'b0, LINE_IDLE);
        add_fixed(CMD_TICK, 0, 1'b0, LINE_IDLE);
        // Zero period, saturated one-high, zero-high of zero, no gap
        add_timing(0, 4095, 0, 0);
        add_fixed(CMD_LOAD, 0, 1'b0, START_LOW);
        for (int i = 0; i < 9; i++)
            add_tick(CMD_TICK, 0, 1'b0);
        add_tick(CMD_LOAD, 2047, 1'b1);
        for (int i = 0; i < 3; i++)
            add_tick(CMD_TICK, 0, 1'b0);
        // Short cells with a short gap
        add_timing(3, 2, 1, 2);
        add_tick(CMD_LOAD, 12'h555, 1'b0);
        add_tick(CMD_TICK, 0, 1'b0);
        add_fixed(CMD_STOP, 0, 1'b0, LINE_IDLE);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the script
        foreach (script[i])
        begin
            if (script[i].reconf)
            begin
                drain_line();
                load_timing(script[i].timing);
            end
            else
                send_tick(script[i].item, script[i].fixed, script[i].want);
        end

        // Randomized phases, one timing set each
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_line();
            case (ph)
                0:  t = {12'd4,    12'd3,    12'd1,    16'd3};
                1:  t = {12'd1,    12'd1,    12'd0,    16'd0};
                2:  t = {12'd0,    12'd0,    12'd4095, 16'd1};
                3:  t = {12'd5,    12'd4095, 12'd4095, 16'd0};
                4:  t = {12'd6,    12'd0,    12'd0,    16'd5};
                5:  t = {12'd4095, 12'd2048, 12'd1,    16'd0};
                6:  t = {12'd2,    12'd1,    12'd2,    16'd65535};
                11: t = {RST_BIT_PERIOD, RST_ONE_HIGH, RST_ZERO_HIGH, RST_GAP};
                default:
                begin
                    t.bit_period = PERIOD_W'($urandom_range(1, 8));
                    t.one_high   = PERIOD_W'($urandom_range(0, 9));
                    t.zero_high  = PERIOD_W'($urandom_range(0, 9));
                    t.gap        = GAP_W'($urandom_range(0, 12));
                end
            endcase
            load_timing(t);
            // Long stretch with no stalls on either side
            steady = (ph == 4 || ph == 5);
            for (int n = 0; n < PHASE_TICKS; n++)
                send_tick(random_item(), 1'b0, LINE_IDLE);
        end

        steady = 1'b0;
        drain_line();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && line_expect.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
